@@ hw/rtl/cupf_pkg.sv @@
`timescale 1ns / 1ps
package cupf_pkg;

   localparam int               WEIGHT_BITS = 16;
   localparam logic [16:0]      WEIGHT_ONE  = 17'd65536;
   localparam logic [16:0]      WEIGHT_HALF = 17'd32768;
   localparam logic signed [63:0] S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN   = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [63:0]        alpha_pair;
      logic [63:0]        density_pair;
      logic [63:0]        energy_pair;
      logic [63:0]        pressure_pair;
      logic [63:0]        sound_speed_pair;
      logic [63:0]        vel_x_pair;
      logic [63:0]        vel_y_pair;
      logic [63:0]        vel_z_pair;
      logic signed [31:0] area_x;
      logic signed [31:0] area_y;
      logic signed [31:0] area_z;
      logic signed [31:0] mesh_flux;
   } req_type;

   typedef struct packed {
      logic signed [63:0] alpha_flux;
      logic signed [63:0] mass_flux;
      logic signed [63:0] momentum_flux_x;
      logic signed [63:0] momentum_flux_y;
      logic signed [63:0] momentum_flux_z;
      logic signed [63:0] total_energy_flux;
      logic signed [63:0] weighted_flux_owner;
      logic signed [63:0] weighted_flux_neighbour;
      logic [16:0]        owner_weight;
      logic signed [31:0] face_vel_x;
      logic signed [31:0] face_vel_y;
      logic signed [31:0] face_vel_z;
   } rsp_type;

   function automatic logic signed [63:0] sx32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   // saturating add / subtract on 64 bits
   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? S64_MIN : S64_MAX;
      return s;
   endfunction

   function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? S64_MIN : S64_MAX;
      return s;
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -64'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

@@ hw/rtl/cupf_delay.sv @@
`timescale 1ns / 1ps
module cupf_delay #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) stage_ff[i] <= stage_ff[i-1];
      end
   end

   assign dout = stage_ff[DEPTH-1];
endmodule

@@ hw/rtl/cupf_fmul.sv @@
`timescale 1ns / 1ps
// round(a*b / 2^SHIFT), ties away from zero, saturated; three stages
module cupf_fmul #(
   parameter int SHIFT = 16
) (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic signed [63:0] prod
);
   localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);

   logic        neg1_ff, neg2_ff;
   logic [63:0] ua_ff, ub_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [63:0] prod_ff, prod_in;
   logic [127:0] full_prod, quot, limit;

   always_comb begin
      full_prod = {64'b0, p00_ff} + {32'b0, p01_ff, 32'b0} + {32'b0, p10_ff, 32'b0}
                + {p11_ff, 64'b0} + RND;
      quot  = full_prod >> SHIFT;
      limit = neg2_ff ? {64'b0, 1'b1, 63'b0} : {65'b0, {63{1'b1}}};
      if (quot > limit) quot = limit;
      prod_in = neg2_ff ? (64'd0 - quot[63:0]) : quot[63:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg1_ff <= a[63] ^ b[63];
         ua_ff   <= a[63] ? (64'd0 - a) : a;
         ub_ff   <= b[63] ? (64'd0 - b) : b;
         neg2_ff <= neg1_ff;
         p00_ff  <= ua_ff[31:0]  * ub_ff[31:0];
         p01_ff  <= ua_ff[31:0]  * ub_ff[63:32];
         p10_ff  <= ua_ff[63:32] * ub_ff[31:0];
         p11_ff  <= ua_ff[63:32] * ub_ff[63:32];
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;
endmodule

@@ hw/rtl/cupf_isqrt.sv @@
`timescale 1ns / 1ps
// floor(sqrt(x)), one result bit per stage, 32 stages
module cupf_isqrt (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] x,
   output logic [31:0] root
);
   // the partial result carries the trial bit at full weight in early stages
   logic [63:0] rem_ff [32];
   logic [63:0] res_ff [32];

   for (genvar i = 0; i < 32; i++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
      logic [63:0] rem_prev, trial, rem_in;
      logic [63:0] res_prev, res_in;
      if (i == 0) begin : g_first
         assign rem_prev = x;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign res_prev = res_ff[i-1];
      end
      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i] <= rem_in;
            res_ff[i] <= res_in;
         end
      end
   end

   assign root = res_ff[31][31:0];
endmodule

@@ hw/rtl/cupf_wdiv.sv @@
`timescale 1ns / 1ps
// owner weight floor(ap * 2^16 / den), restoring divide, one bit per stage
module cupf_wdiv (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] ap,
   input  logic [63:0] den,
   output logic [16:0] weight
);
   import cupf_pkg::*;

   logic [63:0] rem_ff  [WEIGHT_BITS];
   logic [63:0] den_ff  [WEIGHT_BITS];
   logic [15:0] quo_ff  [WEIGHT_BITS];
   logic        zero_ff [WEIGHT_BITS];
   logic        full_ff [WEIGHT_BITS];

   for (genvar i = 0; i < WEIGHT_BITS; i++) begin : g_step
      logic [63:0] rem_prev, den_prev, shifted, rem_in;
      logic [15:0] quo_prev, quo_in;
      logic        zero_prev, full_prev;
      if (i == 0) begin : g_first
         assign rem_prev  = ap;
         assign den_prev  = den;
         assign quo_prev  = '0;
         assign zero_prev = (den == 64'd0);
         assign full_prev = ($signed(ap) >= $signed(den));
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign quo_prev  = quo_ff[i-1];
         assign zero_prev = zero_ff[i-1];
         assign full_prev = full_ff[i-1];
      end
      always_comb begin
         shifted = {rem_prev[62:0], 1'b0};
         if (shifted >= den_prev) begin
            rem_in = shifted - den_prev;
            quo_in = {quo_prev[14:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_prev[14:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]  <= rem_in;
            den_ff[i]  <= den_prev;
            quo_ff[i]  <= quo_in;
            zero_ff[i] <= zero_prev;
            full_ff[i] <= full_prev;
         end
      end
   end

   // no wave speed at all: split evenly; ap at or above den gives the full weight
   assign weight = zero_ff[WEIGHT_BITS-1] ? WEIGHT_HALF :
                   full_ff[WEIGHT_BITS-1] ? WEIGHT_ONE  :
                   {1'b0, quo_ff[WEIGHT_BITS-1]};
endmodule

@@ hw/rtl/central_upwind_phase_face_flux_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   cupf_pkg::req_type (one mesh face)
// rsp_      out        rsp_valid / rsp_stall   cupf_pkg::rsp_type (fluxes of that face)
//
// One face enters per cycle unless req_stall is high; responses leave in request order.
// The depth is set by the chain sqrt (32 stages) -> wave speeds -> weight divide
// (16 stages) -> weighted fluxes -> energy/momentum products (3-stage multipliers).
// Reset (synchronous, active high) clears the valid bits only.
// A stalled response holds the whole pipeline; req_stall rises in the same cycle.
module central_upwind_phase_face_flux_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cupf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cupf_pkg::rsp_type rsp_data
);
   import cupf_pkg::*;

   localparam int LAST = 71;   // stage at which every result is aligned
   localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRAC_BITS - 1);

   // global advance: pipeline moves whenever the output register is free
   logic adv;
   logic [LAST:1] vld_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---- operand unpacking (stage 0, straight from the port)
   logic signed [63:0] u_o [3], u_n [3], sf [3];
   logic signed [63:0] a_o, a_n, r_o, r_n, e_o, e_n, p_o, p_n, c_o, c_n, vm;

   always_comb begin
      u_o[0] = sx32(req_data.vel_x_pair[31:0]);  u_n[0] = sx32(req_data.vel_x_pair[63:32]);
      u_o[1] = sx32(req_data.vel_y_pair[31:0]);  u_n[1] = sx32(req_data.vel_y_pair[63:32]);
      u_o[2] = sx32(req_data.vel_z_pair[31:0]);  u_n[2] = sx32(req_data.vel_z_pair[63:32]);
      sf[0]  = sx32(req_data.area_x);
      sf[1]  = sx32(req_data.area_y);
      sf[2]  = sx32(req_data.area_z);
      a_o = sx32(req_data.alpha_pair[31:0]);       a_n = sx32(req_data.alpha_pair[63:32]);
      r_o = sx32(req_data.density_pair[31:0]);     r_n = sx32(req_data.density_pair[63:32]);
      e_o = sx32(req_data.energy_pair[31:0]);      e_n = sx32(req_data.energy_pair[63:32]);
      p_o = sx32(req_data.pressure_pair[31:0]);    p_n = sx32(req_data.pressure_pair[63:32]);
      c_o = sx32(req_data.sound_speed_pair[31:0]); c_n = sx32(req_data.sound_speed_pair[63:32]);
      vm  = sx32(req_data.mesh_flux);
   end

   function automatic logic [31:0] mag32(input logic signed [63:0] v);
      return v[63] ? (32'd0 - v[31:0]) : v[31:0];
   endfunction

   // ---- sums of squares (squares registered, then summed into a second register; wraps modulo 2^64)
   logic [63:0] sq_sf_ff [3], sq_uo_ff [3], sq_un_ff [3];
   logic [63:0] ss_sf_ff, ss_uo_ff, ss_un_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            sq_sf_ff[k] <= mag32(sf[k])  * mag32(sf[k]);
            sq_uo_ff[k] <= mag32(u_o[k]) * mag32(u_o[k]);
            sq_un_ff[k] <= mag32(u_n[k]) * mag32(u_n[k]);
         end
         ss_sf_ff <= sq_sf_ff[0] + sq_sf_ff[1] + sq_sf_ff[2];
         ss_uo_ff <= sq_uo_ff[0] + sq_uo_ff[1] + sq_uo_ff[2];
         ss_un_ff <= sq_un_ff[0] + sq_un_ff[1] + sq_un_ff[2];
      end
   end

   // |Sf| from the integer square root of the summed squares
   logic [31:0]        root;
   logic signed [63:0] mag_sf;
   cupf_isqrt u_sqrt (.clock, .enable(adv), .x(ss_sf_ff), .root);
   assign mag_sf = {32'b0, root};

   // ---- total energy E = e + |U|^2/2, registered after the sums of squares
   logic signed [63:0] e_o_d2, e_n_d2, eo_ff, en_ff;
   cupf_delay #(.WIDTH(64), .DEPTH(2)) u_deo (.clock, .enable(adv), .din(e_o), .dout(e_o_d2));
   cupf_delay #(.WIDTH(64), .DEPTH(2)) u_den (.clock, .enable(adv), .din(e_n), .dout(e_n_d2));

   always_ff @(posedge clock) begin
      if (adv) begin
         eo_ff <= sadd(e_o_d2, $signed((ss_uo_ff + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1)));
         en_ff <= sadd(e_n_d2, $signed((ss_un_ff + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1)));
      end
   end

   // ---- face-normal fluxes phi (products, then two sum registers, then minus mesh flux)
   logic signed [63:0] pho [3], phn [3];
   for (genvar k = 0; k < 3; k++) begin : g_phi
      cupf_fmul #(.SHIFT(FRAC_BITS)) u_mo (.clock, .enable(adv), .a(u_o[k]), .b(sf[k]),
                                          .prod(pho[k]));
      cupf_fmul #(.SHIFT(FRAC_BITS)) u_mn (.clock, .enable(adv), .a(u_n[k]), .b(sf[k]),
                                          .prod(phn[k]));
   end

   logic signed [63:0] s01_o_ff, s01_n_ff, p2_o_ff, p2_n_ff, s_o_ff, s_n_ff;
   logic signed [63:0] ph_o_ff, ph_n_ff, vm_d5;
   cupf_delay #(.WIDTH(64), .DEPTH(5)) u_dvm5 (.clock, .enable(adv), .din(vm), .dout(vm_d5));

   always_ff @(posedge clock) begin
      if (adv) begin
         s01_o_ff <= sadd(pho[0], pho[1]);
         s01_n_ff <= sadd(phn[0], phn[1]);
         p2_o_ff  <= pho[2];
         p2_n_ff  <= phn[2];
         s_o_ff   <= sadd(s01_o_ff, p2_o_ff);
         s_n_ff   <= sadd(s01_n_ff, p2_n_ff);
         ph_o_ff  <= ssub(s_o_ff, vm_d5);
         ph_n_ff  <= ssub(s_n_ff, vm_d5);
      end
   end

   // ---- pressure terms: alpha*p, then half sum hp
   logic signed [63:0] pa_o, pa_n, psum_ff, dp_ff, hp;
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_pao (.clock, .enable(adv), .a(a_o), .b(p_o), .prod(pa_o));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_pan (.clock, .enable(adv), .a(a_n), .b(p_n), .prod(pa_n));

   always_ff @(posedge clock) begin
      if (adv) begin
         psum_ff <= sadd(pa_o, pa_n);
         dp_ff   <= ssub(pa_o, pa_n);
      end
   end

   cupf_fmul #(.SHIFT(FRAC_BITS)) u_hp (.clock, .enable(adv), .a(psum_ff), .b(HALF_F),
                                       .prod(hp));

   // hp*Sf and mesh-flux work vm*hp, both produced in the same cycle
   logic signed [63:0] sf_d7 [3], hs [3], hs_d70 [3], vm_d7, vmhp, vmhp_d65;
   for (genvar k = 0; k < 3; k++) begin : g_hs
      cupf_delay #(.WIDTH(64), .DEPTH(7)) u_dsf (.clock, .enable(adv), .din(sf[k]),
                                                .dout(sf_d7[k]));
      cupf_fmul #(.SHIFT(FRAC_BITS)) u_m (.clock, .enable(adv), .a(hp), .b(sf_d7[k]),
                                         .prod(hs[k]));
      cupf_delay #(.WIDTH(64), .DEPTH(60)) u_dhs (.clock, .enable(adv), .din(hs[k]),
                                                 .dout(hs_d70[k]));
   end
   cupf_delay #(.WIDTH(64), .DEPTH(7)) u_dvm7 (.clock, .enable(adv), .din(vm), .dout(vm_d7));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_vmhp (.clock, .enable(adv), .a(vm_d7), .b(hp),
                                         .prod(vmhp));
   cupf_delay #(.WIDTH(64), .DEPTH(55)) u_dvmhp (.clock, .enable(adv), .din(vmhp),
                                                .dout(vmhp_d65));

   // ---- enthalpy-like term alpha*(rho*E + p)
   logic signed [63:0] r_o_d3, r_n_d3, re_o, re_n, p_o_d6, p_n_d6, x_o_ff, x_n_ff;
   logic signed [63:0] a_o_d7, a_n_d7, y_o, y_n, y_o_d60, y_n_d60;
   cupf_delay #(.WIDTH(64), .DEPTH(3)) u_dro3 (.clock, .enable(adv), .din(r_o), .dout(r_o_d3));
   cupf_delay #(.WIDTH(64), .DEPTH(3)) u_drn3 (.clock, .enable(adv), .din(r_n), .dout(r_n_d3));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_reo (.clock, .enable(adv), .a(r_o_d3), .b(eo_ff),
                                        .prod(re_o));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_ren (.clock, .enable(adv), .a(r_n_d3), .b(en_ff),
                                        .prod(re_n));
   cupf_delay #(.WIDTH(64), .DEPTH(6)) u_dpo (.clock, .enable(adv), .din(p_o), .dout(p_o_d6));
   cupf_delay #(.WIDTH(64), .DEPTH(6)) u_dpn (.clock, .enable(adv), .din(p_n), .dout(p_n_d6));

   always_ff @(posedge clock) begin
      if (adv) begin
         x_o_ff <= sadd(re_o, p_o_d6);
         x_n_ff <= sadd(re_n, p_n_d6);
      end
   end

   cupf_delay #(.WIDTH(64), .DEPTH(7)) u_dao7 (.clock, .enable(adv), .din(a_o), .dout(a_o_d7));
   cupf_delay #(.WIDTH(64), .DEPTH(7)) u_dan7 (.clock, .enable(adv), .din(a_n), .dout(a_n_d7));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_yo (.clock, .enable(adv), .a(a_o_d7), .b(x_o_ff),
                                       .prod(y_o));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_yn (.clock, .enable(adv), .a(a_n_d7), .b(x_n_ff),
                                       .prod(y_n));
   cupf_delay #(.WIDTH(64), .DEPTH(50)) u_dyo (.clock, .enable(adv), .din(y_o), .dout(y_o_d60));
   cupf_delay #(.WIDTH(64), .DEPTH(50)) u_dyn (.clock, .enable(adv), .din(y_n), .dout(y_n_d60));

   // ---- wave speeds: c*|Sf|, then ap/am, then ap - am
   logic signed [63:0] c_o_d34, c_n_d34, cs_o, cs_n, ph_o_d37, ph_n_d37;
   logic signed [63:0] tp1_ff, tp2_ff, tm1_ff, tm2_ff, ap_ff, am_ff, ap40_ff, den_ff;
   cupf_delay #(.WIDTH(64), .DEPTH(34)) u_dco (.clock, .enable(adv), .din(c_o), .dout(c_o_d34));
   cupf_delay #(.WIDTH(64), .DEPTH(34)) u_dcn (.clock, .enable(adv), .din(c_n), .dout(c_n_d34));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_cso (.clock, .enable(adv), .a(c_o_d34), .b(mag_sf),
                                        .prod(cs_o));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_csn (.clock, .enable(adv), .a(c_n_d34), .b(mag_sf),
                                        .prod(cs_n));
   cupf_delay #(.WIDTH(64), .DEPTH(31)) u_dpho (.clock, .enable(adv), .din(ph_o_ff),
                                               .dout(ph_o_d37));
   cupf_delay #(.WIDTH(64), .DEPTH(31)) u_dphn (.clock, .enable(adv), .din(ph_n_ff),
                                               .dout(ph_n_d37));

   always_ff @(posedge clock) begin
      if (adv) begin
         tp1_ff  <= sadd(ph_o_d37, cs_o);
         tp2_ff  <= sadd(ph_n_d37, cs_n);
         tm1_ff  <= ssub(ph_o_d37, cs_o);
         tm2_ff  <= ssub(ph_n_d37, cs_n);
         // outgoing speed clipped at zero from below, incoming from above
         ap_ff   <= (tp1_ff > tp2_ff) ? ((tp1_ff < 0) ? '0 : tp1_ff)
                                      : ((tp2_ff < 0) ? '0 : tp2_ff);
         am_ff   <= (tm1_ff < tm2_ff) ? ((tm1_ff > 0) ? '0 : tm1_ff)
                                      : ((tm2_ff > 0) ? '0 : tm2_ff);
         ap40_ff <= ap_ff;
         den_ff  <= ssub(ap_ff, am_ff);
      end
   end

   // owner weight from the divide of ap by ap - am
   logic [16:0] w, wn;
   logic signed [63:0] w64, wn64;
   cupf_wdiv u_wdiv (.clock, .enable(adv), .ap(ap40_ff), .den(den_ff), .weight(w));
   assign wn   = WEIGHT_ONE - w;
   assign w64  = {47'b0, w};
   assign wn64 = {47'b0, wn};

   // ---- weighted terms
   logic signed [63:0] am_d56, ph_o_d56, ph_n_d56, asf, wph_o, wph_n;
   logic signed [63:0] u_o_d56 [3], u_n_d56 [3], fvo [3], fvn [3];
   cupf_delay #(.WIDTH(64), .DEPTH(17)) u_dam (.clock, .enable(adv), .din(am_ff), .dout(am_d56));
   cupf_delay #(.WIDTH(64), .DEPTH(50)) u_dpo56 (.clock, .enable(adv), .din(ph_o_ff),
                                                .dout(ph_o_d56));
   cupf_delay #(.WIDTH(64), .DEPTH(50)) u_dpn56 (.clock, .enable(adv), .din(ph_n_ff),
                                                .dout(ph_n_d56));
   cupf_fmul #(.SHIFT(WEIGHT_BITS)) u_asf (.clock, .enable(adv), .a(am_d56), .b(w64),
                                          .prod(asf));
   cupf_fmul #(.SHIFT(WEIGHT_BITS)) u_wpo (.clock, .enable(adv), .a(ph_o_d56), .b(w64),
                                          .prod(wph_o));
   cupf_fmul #(.SHIFT(WEIGHT_BITS)) u_wpn (.clock, .enable(adv), .a(ph_n_d56), .b(wn64),
                                          .prod(wph_n));
   for (genvar k = 0; k < 3; k++) begin : g_fv
      cupf_delay #(.WIDTH(64), .DEPTH(56)) u_duo (.clock, .enable(adv), .din(u_o[k]),
                                                 .dout(u_o_d56[k]));
      cupf_delay #(.WIDTH(64), .DEPTH(56)) u_dun (.clock, .enable(adv), .din(u_n[k]),
                                                 .dout(u_n_d56[k]));
      cupf_fmul #(.SHIFT(WEIGHT_BITS)) u_fo (.clock, .enable(adv), .a(u_o_d56[k]), .b(w64),
                                            .prod(fvo[k]));
      cupf_fmul #(.SHIFT(WEIGHT_BITS)) u_fn (.clock, .enable(adv), .a(u_n_d56[k]), .b(wn64),
                                            .prod(fvn[k]));
   end

   // weighted fluxes and face velocity, registered after the weighted terms
   logic signed [63:0] apo_ff, apn_ff;
   logic signed [31:0] fv_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         apo_ff <= ssub(wph_o, asf);
         apn_ff <= sadd(wph_n, asf);
         for (int k = 0; k < 3; k++) fv_ff[k] <= clamp32(sadd(fvo[k], fvn[k]));
      end
   end

   // pressure work across the face: aSf*(alphaO*pO - alphaN*pN)
   logic signed [63:0] dp_d59, ea, ea_d64;
   cupf_delay #(.WIDTH(64), .DEPTH(55)) u_ddp (.clock, .enable(adv), .din(dp_ff), .dout(dp_d59));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_ea (.clock, .enable(adv), .a(asf), .b(dp_d59), .prod(ea));
   cupf_delay #(.WIDTH(64), .DEPTH(2)) u_dea (.clock, .enable(adv), .din(ea), .dout(ea_d64));

   // ---- alpha flux, mass flux and energy
   logic signed [63:0] a_o_d60, a_n_d60, t_o, t_n, r_o_d63, r_n_d63, m_o, m_n;
   logic signed [63:0] eflux_o, eflux_n, alpha_ff, esum_ff, e1_ff, e2_ff, mass_ff;
   cupf_delay #(.WIDTH(64), .DEPTH(60)) u_dao60 (.clock, .enable(adv), .din(a_o),
                                                .dout(a_o_d60));
   cupf_delay #(.WIDTH(64), .DEPTH(60)) u_dan60 (.clock, .enable(adv), .din(a_n),
                                                .dout(a_n_d60));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_to (.clock, .enable(adv), .a(apo_ff), .b(a_o_d60),
                                       .prod(t_o));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_tn (.clock, .enable(adv), .a(apn_ff), .b(a_n_d60),
                                       .prod(t_n));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_efo (.clock, .enable(adv), .a(apo_ff), .b(y_o_d60),
                                        .prod(eflux_o));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_efn (.clock, .enable(adv), .a(apn_ff), .b(y_n_d60),
                                        .prod(eflux_n));
   cupf_delay #(.WIDTH(64), .DEPTH(63)) u_dro63 (.clock, .enable(adv), .din(r_o),
                                                .dout(r_o_d63));
   cupf_delay #(.WIDTH(64), .DEPTH(63)) u_drn63 (.clock, .enable(adv), .din(r_n),
                                                .dout(r_n_d63));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_mo (.clock, .enable(adv), .a(t_o), .b(r_o_d63), .prod(m_o));
   cupf_fmul #(.SHIFT(FRAC_BITS)) u_mn (.clock, .enable(adv), .a(t_n), .b(r_n_d63), .prod(m_n));

   always_ff @(posedge clock) begin
      if (adv) begin
         alpha_ff <= sadd(t_o, t_n);
         esum_ff  <= sadd(eflux_o, eflux_n);
         e1_ff    <= sadd(esum_ff, ea_d64);
         e2_ff    <= sadd(e1_ff, vmhp_d65);
         mass_ff  <= sadd(m_o, m_n);
      end
   end

   // ---- momentum: convective products, then two sums
   logic signed [63:0] u_o_d66 [3], u_n_d66 [3], mu_o [3], mu_n [3], ms_ff [3], mom_ff [3];
   for (genvar k = 0; k < 3; k++) begin : g_mom
      cupf_delay #(.WIDTH(64), .DEPTH(66)) u_duo (.clock, .enable(adv), .din(u_o[k]),
                                                 .dout(u_o_d66[k]));
      cupf_delay #(.WIDTH(64), .DEPTH(66)) u_dun (.clock, .enable(adv), .din(u_n[k]),
                                                 .dout(u_n_d66[k]));
      cupf_fmul #(.SHIFT(FRAC_BITS)) u_po (.clock, .enable(adv), .a(m_o), .b(u_o_d66[k]),
                                          .prod(mu_o[k]));
      cupf_fmul #(.SHIFT(FRAC_BITS)) u_pn (.clock, .enable(adv), .a(m_n), .b(u_n_d66[k]),
                                          .prod(mu_n[k]));
      always_ff @(posedge clock) begin
         if (adv) begin
            ms_ff[k]  <= sadd(mu_o[k], mu_n[k]);
            mom_ff[k] <= sadd(ms_ff[k], hs_d70[k]);
         end
      end
   end

   // ---- align everything with the momentum flux
   logic signed [63:0] alpha_d, mass_d, energy_d, apo_d, apn_d;
   logic [16:0]        w_d;
   logic signed [31:0] fv_d [3];
   cupf_delay #(.WIDTH(64), .DEPTH(7))  u_dal (.clock, .enable(adv), .din(alpha_ff),
                                              .dout(alpha_d));
   cupf_delay #(.WIDTH(64), .DEPTH(4))  u_dms (.clock, .enable(adv), .din(mass_ff),
                                              .dout(mass_d));
   cupf_delay #(.WIDTH(64), .DEPTH(5))  u_den2 (.clock, .enable(adv), .din(e2_ff),
                                               .dout(energy_d));
   cupf_delay #(.WIDTH(64), .DEPTH(11)) u_dapo (.clock, .enable(adv), .din(apo_ff),
                                               .dout(apo_d));
   cupf_delay #(.WIDTH(64), .DEPTH(11)) u_dapn (.clock, .enable(adv), .din(apn_ff),
                                               .dout(apn_d));
   cupf_delay #(.WIDTH(17), .DEPTH(15)) u_dw (.clock, .enable(adv), .din(w), .dout(w_d));
   for (genvar k = 0; k < 3; k++) begin : g_fvd
      cupf_delay #(.WIDTH(32), .DEPTH(11)) u_d (.clock, .enable(adv), .din(fv_ff[k]),
                                               .dout(fv_d[k]));
   end

   always_comb begin
      rsp_in.alpha_flux              = alpha_d;
      rsp_in.mass_flux               = mass_d;
      rsp_in.momentum_flux_x         = mom_ff[0];
      rsp_in.momentum_flux_y         = mom_ff[1];
      rsp_in.momentum_flux_z         = mom_ff[2];
      rsp_in.total_energy_flux       = energy_d;
      rsp_in.weighted_flux_owner     = apo_d;
      rsp_in.weighted_flux_neighbour = apn_d;
      rsp_in.owner_weight            = w_d;
      rsp_in.face_vel_x              = fv_d[0];
      rsp_in.face_vel_y              = fv_d[1];
      rsp_in.face_vel_z              = fv_d[2];
   end

   // valid bits ride alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LAST-1:1], req_valid};
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- checks
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.owner_weight <= WEIGHT_ONE)
      else $error("owner weight above one");

   a_held_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response lost or changed");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall && !vld_ff[LAST] |=> !rsp_valid)
      else $error("response without a request behind it");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");
endmodule
